@@ rtl/core/ddp_pkg.sv @@
`default_nettype none
package ddp_pkg;

  // Largest payload a single packet may carry; the chunk size register clamps to it.
  localparam int unsigned MAX_CHUNK    = 1440;
  localparam int unsigned HEADER_BYTES = 10;

  localparam int unsigned CHUNK_W = 11;
  localparam int unsigned COUNT_W = 24;
  localparam int unsigned BEAT_W  = $clog2(HEADER_BYTES + 1);

  localparam logic [CHUNK_W-1:0] CHUNK_RESET = (1440 < MAX_CHUNK) ? CHUNK_W'(1440)
                                                                   : CHUNK_W'(MAX_CHUNK);

  localparam logic [7:0] FLAGS_VER1 = 8'h40;
  localparam logic [7:0] FLAG_PUSH  = 8'h01;
  localparam logic [7:0] DATA_TYPE  = 8'h01;
  localparam logic [3:0] SEQ_MASK   = 4'hF;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_DATA  = 1'b1
  } action_t;

  typedef enum logic {
    REG_CHUNK_SIZE = 1'b0,
    REG_DEVICE_ID  = 1'b1
  } cfg_reg_t;

  // Everything the serializer needs to emit the results of one data byte.
  typedef struct packed {
    logic               hdr;
    logic [7:0]         flags;
    logic [3:0]         seq;
    logic [7:0]         dev;
    logic [COUNT_W-1:0] offset;
    logic [CHUNK_W-1:0] size;
    logic [7:0]         data;
    logic               pkt_last;
  } pkt_item_t;

endpackage
`default_nettype wire

@@ rtl/core/ddp_frame_ctl.sv @@
`default_nettype none
module ddp_frame_ctl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_fire,
  input  wire logic                          in_action,
  input  wire logic [ddp_pkg::COUNT_W-1:0]   in_channel_count,
  input  wire logic [7:0]                    in_data_byte,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [ddp_pkg::CHUNK_W-1:0]   cfg_data,
  output logic                               item_valid,
  output ddp_pkg::pkt_item_t                 item
);
  import ddp_pkg::*;

  logic [CHUNK_W-1:0] chunk_size_r;
  logic [7:0]         device_id_r;
  logic [3:0]         seq_r, seq_nxt;
  logic [COUNT_W-1:0] len_r, len_nxt;
  logic [COUNT_W-1:0] off_r, off_nxt;
  logic [CHUNK_W-1:0] left_r, left_nxt;
  logic               active_r, active_nxt;

  logic [COUNT_W-1:0] remain;
  logic [CHUNK_W-1:0] size;
  logic [COUNT_W:0]   end_pos;
  logic               need_hdr;
  logic [CHUNK_W-1:0] left_cur;
  logic [CHUNK_W-1:0] left_dec;
  logic [COUNT_W-1:0] off_inc;
  logic [CHUNK_W-1:0] cs_clamped;

  // Register write with clamp into 1..MAX_CHUNK.
  always_comb begin
    cs_clamped = cfg_data;
    if (cfg_data == '0) begin
      cs_clamped = CHUNK_W'(1);
    end else if (32'(cfg_data) > MAX_CHUNK) begin
      cs_clamped = CHUNK_W'(MAX_CHUNK);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_size_r <= CHUNK_RESET;
      device_id_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CHUNK_SIZE: chunk_size_r <= cs_clamped;
        REG_DEVICE_ID:  device_id_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    remain   = len_r - off_r;
    size     = ({{(COUNT_W-CHUNK_W){1'b0}}, chunk_size_r} < remain) ? chunk_size_r
                                                                     : remain[CHUNK_W-1:0];
    end_pos  = {1'b0, off_r} + {{(COUNT_W+1-CHUNK_W){1'b0}}, size};
    need_hdr = (left_r == '0);
    left_cur = need_hdr ? size : left_r;
    left_dec = left_cur - CHUNK_W'(1);
    off_inc  = off_r + COUNT_W'(1);

    seq_nxt    = seq_r;
    len_nxt    = len_r;
    off_nxt    = off_r;
    left_nxt   = left_r;
    active_nxt = active_r;
    item_valid = 1'b0;

    item.hdr      = need_hdr;
    item.flags    = (end_pos >= {1'b0, len_r}) ? (FLAGS_VER1 | FLAG_PUSH) : FLAGS_VER1;
    item.seq      = seq_r & SEQ_MASK;
    item.dev      = device_id_r;
    item.offset   = off_r;
    item.size     = size;
    item.data     = in_data_byte;
    item.pkt_last = (left_dec == '0);

    if (in_fire) begin
      case (action_t'(in_action))
        ACT_START: begin
          off_nxt  = '0;
          left_nxt = '0;
          if (in_channel_count == '0) begin
            active_nxt = 1'b0;
            len_nxt    = '0;
            seq_nxt    = seq_r + 4'd1;
          end else begin
            active_nxt = 1'b1;
            len_nxt    = in_channel_count;
          end
        end
        ACT_DATA: begin
          if (active_r) begin
            item_valid = 1'b1;
            left_nxt   = left_dec;
            off_nxt    = off_inc;
            if (off_inc >= len_r) begin
              active_nxt = 1'b0;
              left_nxt   = '0;
              seq_nxt    = seq_r + 4'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r    <= '0;
      len_r    <= '0;
      off_r    <= '0;
      left_r   <= '0;
      active_r <= 1'b0;
    end else begin
      seq_r    <= seq_nxt;
      len_r    <= len_nxt;
      off_r    <= off_nxt;
      left_r   <= left_nxt;
      active_r <= active_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/ddp_hdr_ser.sv @@
`default_nettype none
module ddp_hdr_ser (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            item_valid,
  input  wire ddp_pkg::pkt_item_t              item,
  output logic                                 take_ok,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [7:0]                           out_byte,
  output logic                                 out_packet_first,
  output logic                                 out_packet_last,
  output logic                                 out_run_last
);
  import ddp_pkg::*;

  logic                 valid_r;
  logic [BEAT_W-1:0]    beat_r;
  pkt_item_t            item_r;
  logic                 last_beat;
  logic                 out_fire;
  logic [31:0]          off32;
  logic [15:0]          size16;

  assign last_beat = (beat_r == BEAT_W'(HEADER_BYTES));
  assign out_fire  = valid_r && !out_stall;
  // A new item may enter when the register is empty or its final byte leaves now.
  assign take_ok   = !valid_r || (last_beat && !out_stall);

  assign off32  = {{(32-COUNT_W){1'b0}}, item_r.offset};
  assign size16 = {{(16-CHUNK_W){1'b0}}, item_r.size};

  always_comb begin
    case (beat_r)
      4'd0:    out_byte = item_r.flags;
      4'd1:    out_byte = {4'h0, item_r.seq};
      4'd2:    out_byte = DATA_TYPE;
      4'd3:    out_byte = item_r.dev;
      4'd4:    out_byte = off32[31:24];
      4'd5:    out_byte = off32[23:16];
      4'd6:    out_byte = off32[15:8];
      4'd7:    out_byte = off32[7:0];
      4'd8:    out_byte = size16[15:8];
      4'd9:    out_byte = size16[7:0];
      default: out_byte = item_r.data;
    endcase
  end

  assign out_valid        = valid_r;
  assign out_packet_first = (beat_r == '0);
  assign out_packet_last  = last_beat && item_r.pkt_last;
  assign out_run_last     = last_beat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= '0;
    end else if (item_valid && take_ok) begin
      valid_r <= 1'b1;
      beat_r  <= item.hdr ? '0 : BEAT_W'(HEADER_BYTES);
    end else if (out_fire) begin
      if (last_beat) begin
        valid_r <= 1'b0;
      end else begin
        beat_r <= beat_r + BEAT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && take_ok) begin
      item_r <= item;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/ddp_packetizer.sv @@
`default_nettype none
// The first result of an accepted data byte is offered in the cycle after its transfer.
// A payload byte in the middle of a chunk produces a single output byte; the first byte of a chunk
// comes out after ten header bytes, since the output carries one byte per transfer.
// Frame-start items and dropped bytes are consumed on input and produce no transfer out.
// Reset is synchronous, active low; it clears the frame state, sequence and output valid.
module ddp_packetizer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input channel.
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_action,
  input  wire logic [ddp_pkg::COUNT_W-1:0]   in_channel_count,
  input  wire logic [7:0]                    in_data_byte,
  // Configuration write port.
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [ddp_pkg::CHUNK_W-1:0]   cfg_data,
  // Result channel.
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         out_byte,
  output logic                               out_packet_first,
  output logic                               out_packet_last,
  output logic                               out_run_last
);
  import ddp_pkg::*;

  logic      in_fire;
  logic      item_valid;
  logic      take_ok;
  pkt_item_t item;

  // The input is held off only while the output register still has bytes to send
  // other than its final one leaving in this cycle. That keeps one transfer per cycle, while
  // out_stall is low, for payload bytes in a chunk; input stalls only for headers or out_stall.
  assign in_stall = !take_ok;
  assign in_fire  = in_valid && take_ok;

  // Frame bookkeeping: tracks offset, chunk position and sequence, and decides for each
  // data byte whether a header goes in front of it and what the header holds.
  ddp_frame_ctl u_frame_ctl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_fire          (in_fire),
    .in_action        (in_action),
    .in_channel_count (in_channel_count),
    .in_data_byte     (in_data_byte),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .item_valid       (item_valid),
    .item             (item)
  );

  // Output register: holds one item and walks it out a byte per transfer, header first.
  ddp_hdr_ser u_hdr_ser (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item_valid),
    .item             (item),
    .take_ok          (take_ok),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_packet_first (out_packet_first),
    .out_packet_last  (out_packet_last),
    .out_run_last     (out_run_last)
  );

endmodule
`default_nettype wire

@@ test/tb_ddp_packetizer.sv @@
module tb_ddp_packetizer;
  timeunit 1ns;
  timeprecision 1ps;

  import ddp_pkg::*;

  // Cycles without any transfer on either channel before the run is declared hung.
  // The worst legitimate gap is the long receiver hold-off plus random stalls,
  // which stays far below this.
  localparam int QUIET_LIMIT = 4000;
  // Pause before a register write and at the end. The block answers in the cycle
  // after a transfer, so a handful of cycles is ample.
  localparam int SETTLE_CYCLES = 16;
  // Length of the single long receiver hold-off and the input count that starts it.
  localparam int HOLD_CYCLES = 64;
  localparam int HOLD_AFTER = 40;

  // One item on the input channel.
  typedef struct {
    action_t            action;
    logic [COUNT_W-1:0] count;
    logic [7:0]         data;
  } frame_item_t;

  // One byte of the packet stream as the block should present it.
  typedef struct {
    logic [7:0] value;
    logic       first;
    logic       last;
    logic       run_end;
  } wire_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_action = ACT_START;
  logic [COUNT_W-1:0] in_channel_count = '0;
  logic [7:0]         in_data_byte = '0;

  logic               cfg_we = 1'b0;
  logic               cfg_index = REG_CHUNK_SIZE;
  logic [CHUNK_W-1:0] cfg_data = '0;

  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_packet_first;
  logic       out_packet_last;
  logic       out_run_last;

  ddp_packetizer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_channel_count (in_channel_count),
    .in_data_byte     (in_data_byte),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_packet_first (out_packet_first),
    .out_packet_last  (out_packet_last),
    .out_run_last     (out_run_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Items waiting to be offered, and the bytes the block still owes us.
  frame_item_t send_q[$];
  wire_byte_t  due_bytes[$];
  frame_item_t cur_item;

  // Our own copy of the register file, as the block should hold it after clamping.
  logic [CHUNK_W-1:0] chunk_sz = CHUNK_RESET;
  logic [7:0]         dev_id = '0;

  // Our own copy of the framing state.
  logic [3:0]         seq_no = '0;
  logic [COUNT_W-1:0] frm_len = '0;
  logic [COUNT_W-1:0] frm_off = '0;
  logic [CHUNK_W-1:0] chunk_rem = '0;
  logic               frm_open = 1'b0;

  // Percent chance per cycle that the sender or the receiver sits idle.
  int send_idle = 0;
  int recv_idle = 0;

  int errors = 0;
  int in_xfers = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  int quiet = 0;

  task automatic flag_error(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void owe_byte(input logic [7:0] value, input logic first,
                                   input logic last, input logic run_end);
    wire_byte_t b;
    b.value = value;
    b.first = first;
    b.last = last;
    b.run_end = run_end;
    due_bytes.insert(due_bytes.size(), b);
  endfunction

  // Works out the packet stream bytes that one accepted input transfer causes and
  // moves the framing state along with it.
  function automatic void packetize(input frame_item_t it);
    logic [COUNT_W-1:0] remain;
    logic [COUNT_W-1:0] size;
    logic [7:0]         flags;
    if (it.action == ACT_START) begin
      // A start always rewinds to offset zero, abandoning any open frame without
      // touching the sequence number. Only an empty frame advances it.
      frm_off = '0;
      chunk_rem = '0;
      if (it.count == '0) begin
        frm_open = 1'b0;
        frm_len = '0;
        seq_no = seq_no + 4'd1;
      end else begin
        frm_open = 1'b1;
        frm_len = it.count;
      end
    end else if (frm_open) begin
      if (chunk_rem == '0) begin
        // First byte of a chunk: the chunk size is latched here, and the push flag
        // marks the chunk that reaches the end of the frame.
        remain = frm_len - frm_off;
        size = (COUNT_W'(chunk_sz) < remain) ? COUNT_W'(chunk_sz) : remain;
        flags = FLAGS_VER1;
        if (frm_off + size >= frm_len) begin
          flags = flags | FLAG_PUSH;
        end
        owe_byte(flags, 1'b1, 1'b0, 1'b0);
        owe_byte({4'h0, seq_no & SEQ_MASK}, 1'b0, 1'b0, 1'b0);
        owe_byte(DATA_TYPE, 1'b0, 1'b0, 1'b0);
        owe_byte(dev_id, 1'b0, 1'b0, 1'b0);
        owe_byte(8'h00, 1'b0, 1'b0, 1'b0);
        owe_byte(frm_off[23:16], 1'b0, 1'b0, 1'b0);
        owe_byte(frm_off[15:8], 1'b0, 1'b0, 1'b0);
        owe_byte(frm_off[7:0], 1'b0, 1'b0, 1'b0);
        owe_byte(size[15:8], 1'b0, 1'b0, 1'b0);
        owe_byte(size[7:0], 1'b0, 1'b0, 1'b0);
        chunk_rem = size[CHUNK_W-1:0];
      end
      chunk_rem = chunk_rem - CHUNK_W'(1);
      frm_off = frm_off + COUNT_W'(1);
      owe_byte(it.data, 1'b0, chunk_rem == '0, 1'b1);
      if (frm_off >= frm_len) begin
        frm_open = 1'b0;
        chunk_rem = '0;
        seq_no = seq_no + 4'd1;
      end
    end
    // A data byte with no frame open is dropped and owes nothing.
  endfunction

  task automatic queue_start(input logic [COUNT_W-1:0] count);
    frame_item_t it;
    it.action = ACT_START;
    it.count = count;
    it.data = 8'($urandom_range(0, 255));
    send_q.insert(send_q.size(), it);
  endtask

  task automatic queue_byte(input logic [7:0] data);
    frame_item_t it;
    it.action = ACT_DATA;
    it.count = COUNT_W'($urandom());
    it.data = data;
    send_q.insert(send_q.size(), it);
  endtask

  // Mostly complete frames with random content; the rest are truncated frames that
  // the next start abandons, empty frames, and frames with an enormous count.
  // Stray bytes after a finished frame are dropped by the block and not counted.
  task automatic queue_random_part(input int n_items);
    int added;
    int pick;
    int len;
    int sent;
    added = 0;
    while (added < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        len = $urandom_range(1, 16);
        queue_start(COUNT_W'(len));
        for (int k = 0; k < len; k++) queue_byte(8'($urandom_range(0, 255)));
        added += len + 1;
        if ($urandom_range(0, 9) == 0) queue_byte(8'($urandom_range(0, 255)));
      end else if (pick < 80) begin
        len = $urandom_range(2, 16);
        sent = $urandom_range(1, len - 1);
        queue_start(COUNT_W'(len));
        for (int k = 0; k < sent; k++) queue_byte(8'($urandom_range(0, 255)));
        added += sent + 1;
      end else if (pick < 90) begin
        queue_start('0);
        added++;
      end else begin
        len = $urandom_range(1, 5);
        queue_start(COUNT_W'($urandom()));
        for (int k = 0; k < len; k++) queue_byte(8'($urandom_range(0, 255)));
        added += len + 1;
      end
    end
  endtask

  // Waits until every queued item has been transferred and every owed byte has
  // come out, then lets a few more cycles pass so that a trailing start or dropped
  // byte has surely left the block.
  task automatic wait_quiet();
    do @(posedge clk); while (send_q.size() != 0 || in_valid || due_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one register and updates our copy the way the block clamps and masks it.
  task automatic write_reg(input cfg_reg_t idx, input logic [CHUNK_W-1:0] val);
    if (idx == REG_CHUNK_SIZE) begin
      if (val == '0) chunk_sz = CHUNK_W'(1);
      else if (val > CHUNK_W'(MAX_CHUNK)) chunk_sz = CHUNK_W'(MAX_CHUNK);
      else chunk_sz = val;
    end else begin
      dev_id = val[7:0];
    end
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Input driver. The prediction for a transfer is made at the edge that completes
  // it, from the item that was on the port. A new item is only put up when the
  // port is free, so a stalled payload never changes.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_xfers <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        packetize(cur_item);
        in_xfers <= in_xfers + 1;
      end
      if (!in_valid || !in_stall) begin
        if (send_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          cur_item = send_q.pop_front();
          in_valid <= 1'b1;
          in_action <= cur_item.action;
          in_channel_count <= cur_item.count;
          in_data_byte <= cur_item.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_result();
    wire_byte_t want;
    if (due_bytes.size() == 0) begin
      flag_error($sformatf("output byte %02h with nothing outstanding", out_byte));
    end else begin
      want = due_bytes.pop_front();
      if (out_byte !== want.value)
        flag_error($sformatf("byte got %02h want %02h", out_byte, want.value));
      if (out_packet_first !== want.first)
        flag_error($sformatf("packet_first got %b want %b", out_packet_first, want.first));
      if (out_packet_last !== want.last)
        flag_error($sformatf("packet_last got %b want %b", out_packet_last, want.last));
      if (out_run_last !== want.run_end)
        flag_error($sformatf("run_last got %b want %b", out_run_last, want.run_end));
    end
  endtask

  // Output monitor and receiver. Once enough input has gone in, the receiver holds
  // off for a long stretch while the sender keeps offering, so the block backs up
  // and has to stall its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (!hold_done && in_xfers >= HOLD_AFTER) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle);
      end
    end
  end

  // Watchdog: too long without a transfer on either channel means the block hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // First idling mode: the sender idles a little, the receiver about half the time.
    send_idle = 15;
    recv_idle = 52;

    // Reset register values: chunk size at its maximum, device id zero. A byte with
    // no frame open is dropped, an empty frame only bumps the sequence, a short
    // frame fits in one pushed packet, a byte past the end is dropped, and a start
    // in the middle of a frame abandons it.
    queue_byte(8'hA5);
    queue_start('0);
    queue_start(COUNT_W'(3));
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h5A);
    queue_byte(8'h3C);
    queue_start(COUNT_W'(2));
    queue_byte(8'h11);
    queue_start(COUNT_W'(1));
    queue_byte(8'h80);
    wait_quiet();

    // A chunk size of zero clamps to one, so every byte gets its own header. Bits
    // above the id byte are masked off.
    write_reg(REG_CHUNK_SIZE, '0);
    write_reg(REG_DEVICE_ID, 11'h7FF);
    queue_start(COUNT_W'(3));
    queue_byte(8'h01);
    queue_byte(8'hFE);
    queue_byte(8'h7F);
    wait_quiet();

    // The largest count abandoned after two bytes, then a frame left open partway
    // through its first chunk.
    write_reg(REG_CHUNK_SIZE, CHUNK_W'(4));
    write_reg(REG_DEVICE_ID, 11'h2A5);
    queue_start(24'hFFFFFF);
    queue_byte(8'h55);
    queue_byte(8'hAA);
    queue_start(COUNT_W'(6));
    queue_byte(8'h12);
    queue_byte(8'h34);
    wait_quiet();

    // The new size must not cut the chunk already in progress; it applies from the
    // next header on. The random part follows straight behind.
    write_reg(REG_CHUNK_SIZE, CHUNK_W'(2));
    queue_byte(8'h56);
    queue_byte(8'h78);
    queue_byte(8'h9A);
    queue_byte(8'hBC);
    queue_random_part(22);
    wait_quiet();

    // Second idling mode, with a size above the maximum that clamps to it.
    send_idle = 52;
    recv_idle = 15;
    write_reg(REG_CHUNK_SIZE, 11'h7FF);
    write_reg(REG_DEVICE_ID, '0);
    queue_random_part(22);
    wait_quiet();

    // No idling at all, with a small random chunk size and a random id.
    send_idle = 0;
    recv_idle = 0;
    write_reg(REG_CHUNK_SIZE, CHUNK_W'($urandom_range(1, 7)));
    write_reg(REG_DEVICE_ID, CHUNK_W'($urandom_range(0, 2047)));
    queue_random_part(22);
    wait_quiet();

    if (due_bytes.size() != 0) flag_error("bytes still outstanding at the end");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
